@@ src/tfd_pkg.sv @@
// shared types and constants for the typed frame deframer
package tfd_pkg;

  localparam int DEF_MAX_LEN     = 64;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int NUM_SLOTS   = 4;
  localparam int SLOT_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int LEN_REG_W   = 7;
  localparam int OFFSET_W    = 6;
  localparam int OUT_CNT_W   = 16;
  localparam int CFG_IDX_W   = 4;

  localparam logic [BYTE_W-1:0]    SYNC_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0]    END_BYTE  = 8'h55;
  localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_BASE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END       = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_SYNC2   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_ESC     = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_bank;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              rd_bank;
  } mem_ctl_t;

  typedef struct packed {
    logic              done;
    logic              good;
    logic [SLOT_W-1:0] slot;
    logic              rd_hit;
  } res_t;

endpackage

@@ src/typed_frame_deframer_checksum.sv @@
// top level of the typed frame deframer with additive checksum
//
//  channel | handshake              | payload
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in_valid / in_ready    | in_kind, in_rx_byte, in_read_slot, in_read_offset
//  out     | out_valid / out_ready  | out_frame_done .. out_read_data
//
// one item per cycle while the output is not stalled; its result appears in the cycle
// after acceptance, from the output register and the registered memory read port
// in_ready drops only while a result waits on a stalled output
// rst_n is synchronous; the payload memory is not cleared, a published
// byte never written reads as undefined
module typed_frame_deframer_checksum import tfd_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic [SLOT_W-1:0]    in_read_slot,
  input  logic [OFFSET_W-1:0]  in_read_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_done,
  output logic                 out_frame_good,
  output logic [SLOT_W-1:0]    out_frame_slot,
  output logic [OUT_CNT_W-1:0] out_good_frames,
  output logic [OUT_CNT_W-1:0] out_bad_frames,
  output logic [BYTE_W-1:0]    out_read_data
);

  localparam int OFF_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic                   adv;
  mem_ctl_t               mem_ctl;
  logic [OFF_W-1:0]       wr_off;
  logic [BYTE_W-1:0]      wr_data;
  logic [OFF_W-1:0]       rd_off;
  logic [BYTE_W-1:0]      rd_data;
  res_t                   res;
  logic [COUNT_WIDTH-1:0] good_cnt;
  logic [COUNT_WIDTH-1:0] bad_cnt;

  logic                   out_valid_r;
  res_t                   res_r;
  logic [COUNT_WIDTH-1:0] good_r;
  logic [COUNT_WIDTH-1:0] bad_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign adv       = in_valid && in_ready;

  tfd_parser #(
    .MAX_LEN     (MAX_LEN),
    .COUNT_WIDTH (COUNT_WIDTH),
    .OFF_W       (OFF_W)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .adv            (adv),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .in_read_slot   (in_read_slot),
    .in_read_offset (in_read_offset),
    .mem_ctl        (mem_ctl),
    .wr_off         (wr_off),
    .wr_data        (wr_data),
    .rd_off         (rd_off),
    .res            (res),
    .good_cnt       (good_cnt),
    .bad_cnt        (bad_cnt)
  );

  tfd_store #(
    .OFF_W (OFF_W)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_off  (wr_off),
    .wr_data (wr_data),
    .rd_off  (rd_off),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res;
      good_r <= good_cnt;
      bad_r  <= bad_cnt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_done  = res_r.done;
  assign out_frame_good  = res_r.good;
  assign out_frame_slot  = res_r.slot;
  assign out_good_frames = OUT_CNT_W'(good_r);
  assign out_bad_frames  = OUT_CNT_W'(bad_r);
  assign out_read_data   = res_r.rd_hit ? rd_data : '0;

`ifndef SYNTH
  a_good_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_good) |-> out_frame_done)
    else $error("good frame reported without frame end");

  a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_read_data == '0))
    else $error("read data on a frame end result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");
`endif

endmodule

@@ src/tfd_store.sv @@
// payload memory: slot x bank x offset, one write and one registered read port
module tfd_store import tfd_pkg::*; #(
  parameter int OFF_W = 6
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [OFF_W-1:0]  wr_off,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [OFF_W-1:0]  rd_off,
  output logic [BYTE_W-1:0] rd_data
);

  localparam int ADDR_W = SLOT_W + 1 + OFF_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = {ctl.wr_slot, ctl.wr_bank, wr_off};
  assign rd_addr = {ctl.rd_slot, ctl.rd_bank, rd_off};

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/tfd_parser.sv @@
// frame parser, config registers, bank flags and frame counters
module tfd_parser import tfd_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int OFF_W       = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  input  logic                   adv,
  input  logic                   in_kind,
  input  logic [BYTE_W-1:0]      in_rx_byte,
  input  logic [SLOT_W-1:0]      in_read_slot,
  input  logic [OFFSET_W-1:0]    in_read_offset,
  output mem_ctl_t               mem_ctl,
  output logic [OFF_W-1:0]       wr_off,
  output logic [BYTE_W-1:0]      wr_data,
  output logic [OFF_W-1:0]       rd_off,
  output res_t                   res,
  output logic [COUNT_WIDTH-1:0] good_cnt,
  output logic [COUNT_WIDTH-1:0] bad_cnt
);

  localparam int CNT_W = $clog2(MAX_LEN + 2);
  localparam int CW1   = CNT_W + 1;

  logic [BYTE_W-1:0]      type_id_r [NUM_SLOTS];
  logic [LEN_REG_W-1:0]   len_r     [NUM_SLOTS];

  phase_t                 phase_r, phase_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]      sum_r, sum_nxt;
  logic [NUM_SLOTS-1:0]   pub_r, pub_nxt;
  logic [COUNT_WIDTH-1:0] good_cnt_r, good_cnt_nxt;
  logic [COUNT_WIDTH-1:0] bad_cnt_r, bad_cnt_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [OFF_W-1:0]       pend_off_r, pend_off_nxt;
  logic [BYTE_W-1:0]      pend_data_r, pend_data_nxt;

  logic [CW1-1:0]         cur_len;
  logic [CW1-1:0]         cnt_x;
  logic [CW1-1:0]         cnt1;
  logic [SLOT_W-1:0]      match_slot;
  logic                   match_hit;
  logic [BYTE_W-1:0]      sum_esc;
  logic                   st0_v;
  logic                   st1_v;
  logic [OFF_W-1:0]       st0_off;
  logic [OFF_W-1:0]       st1_off;
  logic [BYTE_W-1:0]      st0_data;
  logic [BYTE_W-1:0]      st1_data;

  always_comb begin
    match_slot = '0;
    match_hit  = 1'b0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (type_id_r[s] == in_rx_byte) begin
        match_slot = SLOT_W'(s);
        match_hit  = 1'b1;
      end
    end
  end

  assign cur_len = (32'(len_r[slot_r]) > MAX_LEN) ? CW1'(MAX_LEN) : CW1'(len_r[slot_r]);
  assign cnt_x   = CW1'(cnt_r);
  assign cnt1    = cnt_x + CW1'(1);
  assign sum_esc = sum_r + END_BYTE;

  always_comb begin
    phase_nxt     = phase_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    pub_nxt       = pub_r;
    good_cnt_nxt  = good_cnt_r;
    bad_cnt_nxt   = bad_cnt_r;
    pend_v_nxt    = 1'b0;
    pend_off_nxt  = pend_off_r;
    pend_data_nxt = pend_data_r;
    st0_v         = 1'b0;
    st1_v         = 1'b0;
    st0_off       = '0;
    st1_off       = '0;
    st0_data      = '0;
    st1_data      = '0;
    mem_ctl       = '0;
    wr_off        = '0;
    wr_data       = '0;
    rd_off        = OFF_W'(in_read_offset);
    res           = '0;

    mem_ctl.wr_slot = slot_r;
    mem_ctl.wr_bank = ~pub_r[slot_r];
    mem_ctl.rd_slot = in_read_slot;
    mem_ctl.rd_bank = pub_r[in_read_slot];

    if (adv) begin
      if (in_kind) begin
        mem_ctl.rd_en = 1'b1;
        res.rd_hit    = (32'(in_read_offset) < MAX_LEN);
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (in_rx_byte == SYNC_BYTE) begin
              phase_nxt = PH_SYNC1;
            end
          end
          PH_SYNC1: begin
            phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_IDLE;
          end
          PH_SYNC2: begin
            if (match_hit) begin
              slot_nxt  = match_slot;
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_PAYLOAD: begin
            // escape byte waits for the byte after it
            if (in_rx_byte == END_BYTE) begin
              phase_nxt = PH_ESC;
            end else if (cnt_x <= cur_len) begin
              st0_v    = (cnt_x < cur_len);
              st0_off  = cnt_r[OFF_W-1:0];
              st0_data = in_rx_byte;
              sum_nxt  = sum_r + in_rx_byte;
              cnt_nxt  = CNT_W'(cnt1);
            end else begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
              sum_nxt   = '0;
            end
          end
          PH_ESC: begin
            if (in_rx_byte == END_BYTE) begin
              phase_nxt = PH_END;
            end else if (cnt_x <= cur_len && cnt1 <= cur_len) begin
              st0_v     = (cnt_x < cur_len);
              st0_off   = cnt_r[OFF_W-1:0];
              st0_data  = END_BYTE;
              st1_v     = (cnt1 < cur_len);
              st1_off   = cnt1[OFF_W-1:0];
              st1_data  = in_rx_byte;
              sum_nxt   = sum_esc + in_rx_byte;
              cnt_nxt   = CNT_W'(cnt1 + CW1'(1));
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
              sum_nxt   = '0;
            end
          end
          PH_END: begin
            res.done = 1'b1;
            res.slot = slot_r;
            if (in_rx_byte == sum_r && cnt_x == cur_len) begin
              res.good         = 1'b1;
              pub_nxt[slot_r]  = ~pub_r[slot_r];
              good_cnt_nxt     = good_cnt_r + COUNT_WIDTH'(1);
            end else begin
              bad_cnt_nxt = bad_cnt_r + COUNT_WIDTH'(1);
            end
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end
          default: begin
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end
        endcase
      end
    end

    // single write port: a held byte goes first, the second byte of a pair is held and written in the next cycle
    if (pend_v_r) begin
      mem_ctl.wr_en = 1'b1;
      wr_off        = pend_off_r;
      wr_data       = pend_data_r;
      pend_v_nxt    = st0_v;
      pend_off_nxt  = st0_off;
      pend_data_nxt = st0_data;
    end else begin
      mem_ctl.wr_en = st0_v;
      wr_off        = st0_off;
      wr_data       = st0_data;
      pend_v_nxt    = st1_v;
      pend_off_nxt  = st1_off;
      pend_data_nxt = st1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      slot_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      pub_r       <= '0;
      good_cnt_r  <= '0;
      bad_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      pend_off_r  <= '0;
      pend_data_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      pub_r       <= pub_nxt;
      good_cnt_r  <= good_cnt_nxt;
      bad_cnt_r   <= bad_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_off_r  <= pend_off_nxt;
      pend_data_r <= pend_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        type_id_r[s] <= BYTE_W'(s);
        len_r[s]     <= LEN_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_LEN_BASE) begin
        type_id_r[cfg_index[SLOT_W-1:0]] <= cfg_data;
      end else if (cfg_index < CFG_END) begin
        len_r[cfg_index[SLOT_W-1:0]] <= cfg_data[LEN_REG_W-1:0];
      end
    end
  end

  assign good_cnt = good_cnt_nxt;
  assign bad_cnt  = bad_cnt_nxt;

`ifndef SYNTH
  a_no_write_published: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (mem_ctl.wr_bank != pub_r[mem_ctl.wr_slot]))
    else $error("payload write hit the published bank");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_SYNC1 || phase_r == PH_SYNC2)
      |-> (cnt_r == '0 && sum_r == '0))
    else $error("count or sum left over outside a frame");

  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.good) |=> (good_cnt_r == $past(good_cnt_r) + COUNT_WIDTH'(1)))
    else $error("good counter did not advance on a good frame");

  a_pend_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (phase_r == PH_PAYLOAD))
    else $error("held payload byte outside the payload phase");
`endif

endmodule
